/* src/server_dispatch_scheduler_defines.svh */
// Assertion macros for the checker file of the dispatcher.
// Each expects clk and rst to be visible where it is used.
`ifndef SERVER_DISPATCH_SCHEDULER_DEFINES_SVH
`define SERVER_DISPATCH_SCHEDULER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sds_pkg.sv */
package sds_pkg;

  localparam int NUM_SERVERS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int LOAD_MAX_DEF    = 255;

  localparam int IDX_W     = 3;
  localparam int TAG_W     = 16;
  localparam int SIU_W     = 4;
  localparam int CFG_W     = 4;
  localparam int JOBS_W    = 12;
  localparam int S_TDATA_W = 24;
  localparam int OUT_W     = 35;
  localparam int M_TDATA_W = 40;

  localparam logic [JOBS_W-1:0] JOBS_SAT = 12'hFFF;
  localparam logic [SIU_W-1:0]  SIU_RESET = 4'd8;

  localparam logic REG_POLICY_MODE    = 1'b0;
  localparam logic REG_SERVERS_IN_USE = 1'b1;

  typedef enum logic {CMD_ARRIVAL, CMD_DEPARTURE} cmd_t;
  typedef enum logic {MODE_CENTRAL, MODE_SHORTEST} mode_t;

  typedef enum logic [1:0] {
    ERR_OK,
    ERR_UNDERFLOW,
    ERR_SATURATED,
    ERR_QUEUE_FULL
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic item_load;
    logic start;
    logic scan;
    logic update;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic departure;
    logic idx_valid;
    logic central;
    logic queue_empty;
    logic scan_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

/* src/server_dispatch_scheduler.sv */
// Job dispatcher with one load counter per server and a wait queue.
// Input channel s_*: s_tuser is the command (0 arrival, 1 departure),
// s_tdata carries the server index and the job tag. Output channel m_*:
// one result item for every input item, in order.
// Configuration: cfg_we/cfg_index/cfg_data write the policy mode (index 0)
// and the number of servers in use (index 1); write only while idle.
// An item is taken only when the block is idle. A scan of the counters, one
// counter per cycle over the active servers (at most eight), is needed for an
// arrival with an empty queue, for every arrival in shortest-queue mode and
// for a central departure with jobs waiting; such an item passes through the
// start, scan, update and finish states. A central arrival that joins a
// non-empty queue skips the scan, and a departure that needs no scan goes
// from start straight to finish. A new item is taken only once the block is
// back in idle after the last result has been registered.
// The result sits in an output register; a stalled receiver holds it there
// and the block finishes its next item only once the register is free.
// Reset clears all counters, the queue pointers, the job total and the
// configuration (central mode, eight servers in use); it takes effect at
// once, with no clearing pass.
module server_dispatch_scheduler #(
  parameter int NUM_SERVERS = sds_pkg::NUM_SERVERS_DEF,
  parameter int QUEUE_DEPTH = sds_pkg::QUEUE_DEPTH_DEF,
  parameter int LOAD_MAX    = sds_pkg::LOAD_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // server_index [2:0], job_tag [18:3], zero [23:19]
  input  logic [sds_pkg::S_TDATA_W-1:0] s_tdata,
  // command [0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // dispatched [0], dest_server [3:1], sent_tag [19:4], enqueued [20],
  // jobs_present [32:21], error_code [34:33], zero [39:35]
  output logic [sds_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sds_pkg::CFG_W-1:0]     cfg_data
);

  sds_pkg::ctrl_cmd_t  cmd;
  sds_pkg::ctrl_stat_t stat;

  sds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sds_datapath #(
    .NUM_SERVERS (NUM_SERVERS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LOAD_MAX    (LOAD_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

/* src/sds_ctrl.sv */
module sds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  sds_pkg::ctrl_stat_t stat,
  output sds_pkg::ctrl_cmd_t  cmd
);

  sds_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sds_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = sds_pkg::ST_START;
      end
      sds_pkg::ST_START: begin
        if (stat.departure) begin
          // Only a real departure in central mode with jobs waiting needs a scan.
          if (!stat.idx_valid || !stat.central || stat.queue_empty) begin
            state_next = sds_pkg::ST_FINISH;
          end else begin
            state_next = sds_pkg::ST_SCAN;
          end
        end else if (stat.central && !stat.queue_empty) begin
          state_next = sds_pkg::ST_UPDATE;
        end else begin
          state_next = sds_pkg::ST_SCAN;
        end
      end
      sds_pkg::ST_SCAN: begin
        if (stat.scan_last) state_next = sds_pkg::ST_UPDATE;
      end
      sds_pkg::ST_UPDATE: begin
        state_next = sds_pkg::ST_FINISH;
      end
      sds_pkg::ST_FINISH: begin
        if (stat.out_free) state_next = sds_pkg::ST_IDLE;
      end
      default: begin
        state_next = sds_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready      = (state == sds_pkg::ST_IDLE);
    cmd.item_load = (state == sds_pkg::ST_IDLE) && s_tvalid;
    cmd.start     = (state == sds_pkg::ST_START);
    cmd.scan      = (state == sds_pkg::ST_SCAN);
    cmd.update    = (state == sds_pkg::ST_UPDATE);
    cmd.finish    = (state == sds_pkg::ST_FINISH) && stat.out_free;
  end

endmodule

/* src/sds_datapath.sv */
module sds_datapath #(
  parameter int NUM_SERVERS = sds_pkg::NUM_SERVERS_DEF,
  parameter int QUEUE_DEPTH = sds_pkg::QUEUE_DEPTH_DEF,
  parameter int LOAD_MAX    = sds_pkg::LOAD_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [sds_pkg::CFG_W-1:0]       cfg_data,
  input  logic [sds_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  input  sds_pkg::ctrl_cmd_t              cmd,
  output sds_pkg::ctrl_stat_t             stat,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sds_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int SW  = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int NW  = $clog2(NUM_SERVERS + 1);
  localparam int CW  = (NW > sds_pkg::SIU_W) ? NW : sds_pkg::SIU_W;
  localparam int LW  = $clog2(LOAD_MAX + 1);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int LNW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW0 = $clog2(QUEUE_DEPTH + NUM_SERVERS * LOAD_MAX + 1);
  localparam int TW  = (TW0 > sds_pkg::JOBS_W) ? TW0 : sds_pkg::JOBS_W;
  localparam int PAD = sds_pkg::M_TDATA_W - sds_pkg::OUT_W;

  // Configuration
  sds_pkg::mode_t             policy_mode;
  logic [sds_pkg::SIU_W-1:0]  servers_in_use;

  // Item under work
  sds_pkg::cmd_t              item_cmd;
  logic [sds_pkg::IDX_W-1:0]  item_idx;
  logic [sds_pkg::TAG_W-1:0]  item_tag;

  // Server counters, wait queue and job total
  logic [LW-1:0]              server_load [NUM_SERVERS];
  logic [sds_pkg::TAG_W-1:0]  qmem [QUEUE_DEPTH];
  logic [sds_pkg::TAG_W-1:0]  q_rd;
  logic [QW-1:0]              q_head;
  logic [QW-1:0]              q_tail;
  logic [LNW-1:0]             q_len;
  logic [TW-1:0]              total;

  // Scan state
  logic [SW-1:0]              scan_i;
  logic [SW-1:0]              best;
  logic [LW-1:0]              best_load;
  logic                       found;

  // Result staging
  logic                       res_dispatched;
  logic [sds_pkg::IDX_W-1:0]  res_dest;
  logic [sds_pkg::TAG_W-1:0]  res_tag;
  logic                       res_enq;
  sds_pkg::err_t              res_err;

  logic [CW-1:0]              siu_ext;
  logic [CW-1:0]              active;
  logic [SW-1:0]              last_idx;
  logic [SW-1:0]              idx_addr;
  logic [SW-1:0]              ld_addr;
  logic [LW-1:0]              load_rd;
  logic                       idx_valid;
  logic                       arrival;
  logic                       central;
  logic                       q_empty;
  logic                       q_full;
  logic                       dec_ok;
  logic                       do_dispatch;
  logic                       do_push;
  sds_pkg::err_t              up_err;
  logic [sds_pkg::JOBS_W-1:0] jobs_sat;

  always_comb begin
    siu_ext = CW'(servers_in_use);
    if (siu_ext == '0) begin
      active = CW'(1);
    end else if (siu_ext > CW'(NUM_SERVERS)) begin
      active = CW'(NUM_SERVERS);
    end else begin
      active = siu_ext;
    end
    last_idx = SW'(active - CW'(1));
  end

  assign idx_valid = int'(item_idx) < NUM_SERVERS;
  assign idx_addr  = SW'(item_idx);
  assign arrival   = (item_cmd == sds_pkg::CMD_ARRIVAL);
  assign central   = (policy_mode == sds_pkg::MODE_CENTRAL);
  assign q_empty   = (q_len == '0);
  assign q_full    = (q_len == LNW'(QUEUE_DEPTH));

  // The counter file has a single read port, steered by the current step.
  always_comb begin
    if (cmd.start) begin
      ld_addr = idx_addr;
    end else if (cmd.update) begin
      ld_addr = best;
    end else begin
      ld_addr = scan_i;
    end
  end

  assign load_rd = server_load[ld_addr];
  assign dec_ok  = !arrival && idx_valid && (load_rd != '0);

  always_comb begin
    do_dispatch = 1'b0;
    do_push     = 1'b0;
    up_err      = sds_pkg::ERR_OK;
    if (arrival) begin
      if (central) begin
        if (!q_empty || !found) begin
          if (q_full) begin
            up_err = sds_pkg::ERR_QUEUE_FULL;
          end else begin
            do_push = 1'b1;
          end
        end else begin
          do_dispatch = 1'b1;
        end
      end else if (best_load >= LW'(LOAD_MAX)) begin
        up_err = sds_pkg::ERR_SATURATED;
      end else begin
        do_dispatch = 1'b1;
      end
    end else begin
      // A departure reaches this step only with jobs waiting in central mode.
      do_dispatch = found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode    <= sds_pkg::MODE_CENTRAL;
      servers_in_use <= sds_pkg::SIU_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sds_pkg::REG_POLICY_MODE:    policy_mode    <= sds_pkg::mode_t'(cfg_data[0]);
        sds_pkg::REG_SERVERS_IN_USE: servers_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_cmd <= sds_pkg::cmd_t'(s_tuser);
      item_idx <= s_tdata[sds_pkg::IDX_W-1:0];
      item_tag <= s_tdata[sds_pkg::IDX_W +: sds_pkg::TAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SERVERS; i++) begin
        server_load[i] <= '0;
      end
      q_head <= '0;
      q_tail <= '0;
      q_len  <= '0;
      total  <= '0;
    end else if (cmd.start) begin
      if (dec_ok) begin
        server_load[ld_addr] <= load_rd - LW'(1);
        total                <= total - TW'(1);
      end
    end else if (cmd.update) begin
      if (do_dispatch) begin
        server_load[ld_addr] <= load_rd + LW'(1);
      end
      if (do_push) begin
        q_tail <= (q_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : q_tail + QW'(1);
        q_len  <= q_len + LNW'(1);
      end
      // A queued job moving to a server leaves the total unchanged.
      if (do_dispatch && !arrival) begin
        q_head <= (q_head == QW'(QUEUE_DEPTH - 1)) ? '0 : q_head + QW'(1);
        q_len  <= q_len - LNW'(1);
      end
      if (do_push || (do_dispatch && arrival)) begin
        total <= total + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && do_push) begin
      qmem[q_tail] <= item_tag;
    end
    q_rd <= qmem[q_head];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      scan_i    <= '0;
      best      <= '0;
      best_load <= '0;
      found     <= 1'b0;
    end else if (cmd.scan) begin
      if (central) begin
        if (!found && (load_rd == '0)) begin
          found <= 1'b1;
          best  <= scan_i;
        end
      end else if ((scan_i == '0) || (load_rd < best_load)) begin
        best      <= scan_i;
        best_load <= load_rd;
      end
      if (scan_i != last_idx) begin
        scan_i <= scan_i + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_dispatched <= 1'b0;
      res_dest       <= '0;
      res_tag        <= '0;
      res_enq        <= 1'b0;
      res_err        <= (!arrival && idx_valid && (load_rd == '0)) ?
                        sds_pkg::ERR_UNDERFLOW : sds_pkg::ERR_OK;
    end else if (cmd.update) begin
      if (do_dispatch) begin
        res_dispatched <= 1'b1;
        res_dest       <= sds_pkg::IDX_W'(best);
        res_tag        <= arrival ? item_tag : q_rd;
      end
      res_enq <= do_push;
      if (up_err != sds_pkg::ERR_OK) begin
        res_err <= up_err;
      end
    end
  end

  assign jobs_sat = (total > TW'(sds_pkg::JOBS_SAT)) ? sds_pkg::JOBS_SAT
                                                     : total[sds_pkg::JOBS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {{PAD{1'b0}}, res_err, jobs_sat, res_enq, res_tag, res_dest,
                  res_dispatched};
    end
  end

  always_comb begin
    stat.departure   = !arrival;
    stat.idx_valid   = idx_valid;
    stat.central     = central;
    stat.queue_empty = q_empty;
    stat.scan_last   = (scan_i == last_idx);
    stat.out_free    = !m_tvalid || m_tready;
  end

endmodule

/* src/sds_checker.sv */
`include "server_dispatch_scheduler_defines.svh"

module sds_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sds_pkg::M_TDATA_W-1:0] m_tdata
);

  // A result that is not taken keeps its value.
  `SDS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // Items are worked one at a time, so no item is taken right after another.
  `SDS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item taken while another is in work")

  // A job is either sent to a server or queued, never both.
  `SDS_ASSERT_NOW(a_disp_enq, m_tvalid, !(m_tdata[0] && m_tdata[20]), "job both dispatched and queued")

  // A dropped job is neither sent nor queued.
  `SDS_ASSERT_NOW(a_drop, m_tvalid && (m_tdata[34:33] == sds_pkg::ERR_SATURATED || m_tdata[34:33] == sds_pkg::ERR_QUEUE_FULL), !m_tdata[0] && !m_tdata[20], "dropped job reported as placed")

  // Without a dispatch the destination and tag read as zero.
  `SDS_ASSERT_NOW(a_idle_fields, m_tvalid && !m_tdata[0], m_tdata[19:1] == 19'd0, "fields set without a dispatch")

endmodule

bind server_dispatch_scheduler sds_checker u_sds_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/server_dispatch_scheduler_test.sv */
module server_dispatch_scheduler_test;

  typedef struct {
    logic                       dispatched;
    logic [sds_pkg::IDX_W-1:0]  dest;
    logic [sds_pkg::TAG_W-1:0]  tag;
    logic                       enq;
    logic [sds_pkg::JOBS_W-1:0] jobs;
    sds_pkg::err_t              err;
  } outcome_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    sds_pkg::cmd_t             cmd;
    logic [sds_pkg::IDX_W-1:0] idx;
    logic [sds_pkg::TAG_W-1:0] tag;
    bit                        typed;
    outcome_t                  want;
    logic                      reg_sel;
    logic [sds_pkg::CFG_W-1:0] value;
  } stim_row_t;

  localparam logic [10:0] READY_PATTERN = 11'b10110111001;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES = 9;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  // server_index [2:0], job_tag [18:3], zero [23:19]
  logic [sds_pkg::S_TDATA_W-1:0] s_tdata = '0;
  // command [0]
  logic                          s_tuser = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  // dispatched [0], dest_server [3:1], sent_tag [19:4], enqueued [20],
  // jobs_present [32:21], error_code [34:33], zero [39:35]
  logic [sds_pkg::M_TDATA_W-1:0] m_tdata;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = 1'b0;
  logic [sds_pkg::CFG_W-1:0]     cfg_data = '0;

  // Shadow of the dispatcher state.
  int unsigned               load_seen [sds_pkg::NUM_SERVERS_DEF];
  logic [sds_pkg::TAG_W-1:0] waiting_tags [$];
  sds_pkg::mode_t            mode_now = sds_pkg::MODE_CENTRAL;
  logic [sds_pkg::SIU_W-1:0] servers_now = sds_pkg::SIU_RESET;

  outcome_t  awaited_results [$];
  outcome_t  no_typed_outcome;
  stim_row_t stim_rows [$];
  int        fault_count = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  logic [15:0] rx_cycle = '0;

  sds_pkg::mode_t phase_mode [PHASES] = '{
    sds_pkg::MODE_SHORTEST, sds_pkg::MODE_CENTRAL, sds_pkg::MODE_CENTRAL,
    sds_pkg::MODE_SHORTEST, sds_pkg::MODE_CENTRAL, sds_pkg::MODE_SHORTEST,
    sds_pkg::MODE_CENTRAL, sds_pkg::MODE_SHORTEST, sds_pkg::MODE_CENTRAL};
  int phase_servers [PHASES] = '{1, 1, 8, 8, 0, 15, 3, 0, 15};
  int phase_items [PHASES] = '{280, 100, 120, 120, 60, 80, 80, 40, 60};
  int phase_arrival_pct [PHASES] = '{98, 92, 35, 55, 65, 50, 55, 50, 40};

  server_dispatch_scheduler uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #8000000;
    $display("server_dispatch_scheduler_test: done, errors");
    $finish;
  end

  function automatic int active_servers();
    if (servers_now == 0) return 1;
    if (servers_now > sds_pkg::NUM_SERVERS_DEF) return sds_pkg::NUM_SERVERS_DEF;
    return int'(servers_now);
  endfunction

  // Returns NUM_SERVERS_DEF when every active server is busy.
  function automatic int first_idle_server();
    int n;
    n = active_servers();
    for (int i = 0; i < n; i++)
      if (load_seen[i] == 0) return i;
    return sds_pkg::NUM_SERVERS_DEF;
  endfunction

  function automatic outcome_t dispatch_outcome(sds_pkg::cmd_t cmd,
                                                logic [sds_pkg::IDX_W-1:0] idx,
                                                logic [sds_pkg::TAG_W-1:0] tag);
    outcome_t o;
    int s;
    int best;
    int total;
    o.dispatched = 1'b0;
    o.dest = '0;
    o.tag = '0;
    o.enq = 1'b0;
    o.jobs = '0;
    o.err = sds_pkg::ERR_OK;
    if (cmd == sds_pkg::CMD_ARRIVAL) begin
      if (mode_now == sds_pkg::MODE_CENTRAL) begin
        // Waiting jobs keep their turn: a new arrival joins the back of the queue.
        s = (waiting_tags.size() != 0) ? sds_pkg::NUM_SERVERS_DEF : first_idle_server();
        if (s < sds_pkg::NUM_SERVERS_DEF) begin
          load_seen[s]++;
          o.dispatched = 1'b1;
          o.dest = s[sds_pkg::IDX_W-1:0];
          o.tag = tag;
        end else if (waiting_tags.size() < sds_pkg::QUEUE_DEPTH_DEF) begin
          waiting_tags.push_back(tag);
          o.enq = 1'b1;
        end else begin
          o.err = sds_pkg::ERR_QUEUE_FULL;
        end
      end else begin
        best = 0;
        for (int i = 1; i < active_servers(); i++)
          if (load_seen[i] < load_seen[best]) best = i;
        if (load_seen[best] >= sds_pkg::LOAD_MAX_DEF) begin
          o.err = sds_pkg::ERR_SATURATED;
        end else begin
          load_seen[best]++;
          o.dispatched = 1'b1;
          o.dest = best[sds_pkg::IDX_W-1:0];
          o.tag = tag;
        end
      end
    end else begin
      if (load_seen[idx] == 0) o.err = sds_pkg::ERR_UNDERFLOW;
      else load_seen[idx]--;
      if (mode_now == sds_pkg::MODE_CENTRAL && waiting_tags.size() != 0) begin
        s = first_idle_server();
        if (s < sds_pkg::NUM_SERVERS_DEF) begin
          load_seen[s]++;
          o.dispatched = 1'b1;
          o.dest = s[sds_pkg::IDX_W-1:0];
          o.tag = waiting_tags.pop_front();
        end
      end
    end
    total = waiting_tags.size();
    foreach (load_seen[i]) total += load_seen[i];
    if (total > sds_pkg::JOBS_SAT) total = sds_pkg::JOBS_SAT;
    o.jobs = total[sds_pkg::JOBS_W-1:0];
    return o;
  endfunction

  function automatic void add_item(sds_pkg::cmd_t cmd, logic [sds_pkg::IDX_W-1:0] idx,
                                   logic [sds_pkg::TAG_W-1:0] tag);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.cmd = cmd;
    r.idx = idx;
    r.tag = tag;
    r.typed = 1'b0;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_typed(sds_pkg::cmd_t cmd, logic [sds_pkg::IDX_W-1:0] idx,
                                    logic [sds_pkg::TAG_W-1:0] tag,
                                    logic dsp, logic [sds_pkg::IDX_W-1:0] dest,
                                    logic [sds_pkg::TAG_W-1:0] sent, logic enq,
                                    logic [sds_pkg::JOBS_W-1:0] jobs, sds_pkg::err_t err);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.cmd = cmd;
    r.idx = idx;
    r.tag = tag;
    r.typed = 1'b1;
    r.want.dispatched = dsp;
    r.want.dest = dest;
    r.want.tag = sent;
    r.want.enq = enq;
    r.want.jobs = jobs;
    r.want.err = err;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic reg_sel, logic [sds_pkg::CFG_W-1:0] value);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.reg_sel = reg_sel;
    r.value = value;
    stim_rows.push_back(r);
  endfunction

  task automatic send_item(sds_pkg::cmd_t cmd, logic [sds_pkg::IDX_W-1:0] idx,
                           logic [sds_pkg::TAG_W-1:0] tag, bit typed, outcome_t want);
    outcome_t guess;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {5'b00000, tag, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    guess = dispatch_outcome(cmd, idx, tag);
    awaited_results.push_back(typed ? want : guess);
    items_sent++;
  endtask

  // Sender pacing: bursts with random gaps, and now and then a full drain.
  task automatic pace_sender();
    if (items_sent % 97 == 0) begin
      s_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk);
    end else if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : int'($urandom_range(1, 8));
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(logic reg_sel, logic [sds_pkg::CFG_W-1:0] value);
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= reg_sel;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (reg_sel == sds_pkg::REG_POLICY_MODE) mode_now = sds_pkg::mode_t'(value[0]);
    else servers_now = value;
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    outcome_t want;
    rx_cycle <= rx_cycle + 16'd1;
    // Open stretches alternate with a stall pattern and an occasional long stall.
    m_tready <= rx_cycle[9] || (rx_cycle[8:4] != 5'h1F && READY_PATTERN[rx_cycle % 11]);
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result item with nothing awaited: %h", m_tdata);
        fault_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("dispatched", want.dispatched, m_tdata[0]);
        check_field("dest_server", want.dest, m_tdata[3:1]);
        check_field("sent_tag", want.tag, m_tdata[19:4]);
        check_field("enqueued", want.enq, m_tdata[20]);
        check_field("jobs_present", want.jobs, m_tdata[32:21]);
        check_field("error_code", want.err, m_tdata[34:33]);
      end
    end
  end

  initial begin : stimulus
    stim_row_t r;
    sds_pkg::cmd_t cmd;
    logic [sds_pkg::IDX_W-1:0] idx;
    logic [sds_pkg::TAG_W-1:0] tag;
    int pick;

    foreach (load_seen[i]) load_seen[i] = 0;

    // Central mode with eight servers: fill every server, then queue two jobs.
    add_typed(sds_pkg::CMD_DEPARTURE, 3'd0, 16'h0000, 1'b0, 3'd0, 16'h0000, 1'b0, 12'd0,
              sds_pkg::ERR_UNDERFLOW);
    add_typed(sds_pkg::CMD_ARRIVAL, 3'd0, 16'hFFFF, 1'b1, 3'd0, 16'hFFFF, 1'b0, 12'd1,
              sds_pkg::ERR_OK);
    add_typed(sds_pkg::CMD_ARRIVAL, 3'd7, 16'h0000, 1'b1, 3'd1, 16'h0000, 1'b0, 12'd2,
              sds_pkg::ERR_OK);
    add_typed(sds_pkg::CMD_ARRIVAL, 3'd0, 16'h5555, 1'b1, 3'd2, 16'h5555, 1'b0, 12'd3,
              sds_pkg::ERR_OK);
    add_typed(sds_pkg::CMD_ARRIVAL, 3'd5, 16'hAAAA, 1'b1, 3'd3, 16'hAAAA, 1'b0, 12'd4,
              sds_pkg::ERR_OK);
    add_typed(sds_pkg::CMD_ARRIVAL, 3'd2, 16'h0001, 1'b1, 3'd4, 16'h0001, 1'b0, 12'd5,
              sds_pkg::ERR_OK);
    add_typed(sds_pkg::CMD_ARRIVAL, 3'd0, 16'h8000, 1'b1, 3'd5, 16'h8000, 1'b0, 12'd6,
              sds_pkg::ERR_OK);
    add_typed(sds_pkg::CMD_ARRIVAL, 3'd0, 16'h1234, 1'b1, 3'd6, 16'h1234, 1'b0, 12'd7,
              sds_pkg::ERR_OK);
    add_typed(sds_pkg::CMD_ARRIVAL, 3'd0, 16'h7FFE, 1'b1, 3'd7, 16'h7FFE, 1'b0, 12'd8,
              sds_pkg::ERR_OK);
    add_typed(sds_pkg::CMD_ARRIVAL, 3'd0, 16'h00FF, 1'b0, 3'd0, 16'h0000, 1'b1, 12'd9,
              sds_pkg::ERR_OK);
    add_typed(sds_pkg::CMD_ARRIVAL, 3'd0, 16'hFF00, 1'b0, 3'd0, 16'h0000, 1'b1, 12'd10,
              sds_pkg::ERR_OK);
    add_typed(sds_pkg::CMD_DEPARTURE, 3'd7, 16'h0000, 1'b1, 3'd7, 16'h00FF, 1'b0, 12'd9,
              sds_pkg::ERR_OK);
    // A departure from a server outside the active set still decrements it.
    add_cfg(sds_pkg::REG_SERVERS_IN_USE, 4'd4);
    add_item(sds_pkg::CMD_DEPARTURE, 3'd6, 16'hBEEF);
    add_item(sds_pkg::CMD_ARRIVAL, 3'd1, 16'h4321);
    add_cfg(sds_pkg::REG_POLICY_MODE, {3'b000, sds_pkg::MODE_SHORTEST});
    add_item(sds_pkg::CMD_ARRIVAL, 3'd0, 16'h2222);
    add_item(sds_pkg::CMD_DEPARTURE, 3'd5, 16'h0000);
    // Zero servers in use behaves as one, anything above eight as eight.
    add_cfg(sds_pkg::REG_SERVERS_IN_USE, 4'd0);
    add_item(sds_pkg::CMD_ARRIVAL, 3'd3, 16'h3333);
    add_cfg(sds_pkg::REG_SERVERS_IN_USE, 4'd15);
    add_item(sds_pkg::CMD_ARRIVAL, 3'd4, 16'h6666);
    add_cfg(sds_pkg::REG_POLICY_MODE, {3'b000, sds_pkg::MODE_CENTRAL});
    add_item(sds_pkg::CMD_DEPARTURE, 3'd3, 16'h0000);
    add_item(sds_pkg::CMD_DEPARTURE, 3'd4, 16'h0000);
    add_item(sds_pkg::CMD_DEPARTURE, 3'd2, 16'hFFFF);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      r = stim_rows[i];
      if (r.kind == ROW_CFG) begin
        write_reg(r.reg_sel, r.value);
      end else begin
        send_item(r.cmd, r.idx, r.tag, r.typed, r.want);
        pace_sender();
      end
    end

    // The early phases drive one server to its load ceiling and then fill the queue.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(sds_pkg::REG_POLICY_MODE, {3'b000, phase_mode[p]});
      write_reg(sds_pkg::REG_SERVERS_IN_USE, phase_servers[p][sds_pkg::CFG_W-1:0]);
      for (int k = 0; k < phase_items[p]; k++) begin
        cmd = ($urandom_range(0, 99) < phase_arrival_pct[p]) ? sds_pkg::CMD_ARRIVAL
                                                             : sds_pkg::CMD_DEPARTURE;
        if ($urandom_range(0, 3) != 0)
          idx = sds_pkg::IDX_W'($urandom_range(0, active_servers() - 1));
        else
          idx = sds_pkg::IDX_W'($urandom_range(0, sds_pkg::NUM_SERVERS_DEF - 1));
        pick = int'($urandom_range(0, 9));
        if (pick == 0) tag = 16'hFFFF;
        else if (pick == 1) tag = 16'h0000;
        else tag = sds_pkg::TAG_W'($urandom_range(0, 16'hFFFF));
        send_item(cmd, idx, tag, 1'b0, no_typed_outcome);
        pace_sender();
      end
    end

    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("server_dispatch_scheduler_test: done, clean");
    end else begin
      $display("server_dispatch_scheduler_test: done, errors");
    end
    $finish;
  end

endmodule
